/* rtl/fsms_pkg.sv */
// ----------------------------------------------------------------------------
// fsms_pkg
// Shared types and codes for the feature standardiser / max-abs scaler.
// ----------------------------------------------------------------------------
package fsms_pkg;

    localparam int MaxFeatures = 16;
    localparam int FeatIdxW    = $clog2(MaxFeatures);
    localparam int FeatCntW    = 5;
    localparam int DataW       = 16;
    localparam int SumW        = 32;
    localparam int SumSqW      = 48;
    localparam int MaxAbsW     = 16;
    localparam int MeanW       = 24;
    localparam int StdW        = 24;
    localparam int CountW      = 16;
    localparam int StatW       = SumW + SumSqW + MaxAbsW;
    localparam int MsW         = MeanW + StdW;
    localparam int DvdW        = 80;
    localparam int DenW        = 32;
    localparam int DivCntW     = 7;

    localparam logic [CountW-1:0] SampleLimit = 16'hFFFF;

    // request codes
    localparam logic [1:0] REQ_CLEAR    = 2'd0;
    localparam logic [1:0] REQ_TRAIN    = 2'd1;
    localparam logic [1:0] REQ_FINALIZE = 2'd2;
    localparam logic [1:0] REQ_SCALE    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_STD = 2'd1;
    localparam logic [1:0] ST_NO_SAMP  = 2'd2;
    localparam logic [1:0] ST_BAD_IDX  = 2'd3;

    // register indexes
    localparam logic REG_FEATURE_COUNT = 1'b0;
    localparam logic REG_SCALE_MODE    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TR_RD,
        S_TR_WR,
        S_FN_RD,
        S_FN_LD,
        S_FN_MUL,
        S_FN_SUB,
        S_FN_MDIV,
        S_FN_MEAN,
        S_FN_SDIV,
        S_FN_SQLD,
        S_FN_SQRT,
        S_FN_WB,
        S_SC_RD,
        S_SC_LD,
        S_SC_DIV
    } fsms_state_t;

endpackage

/* rtl/feature_standardize_maxabs_scaler.sv */
// ----------------------------------------------------------------------------
// feature_standardize_maxabs_scaler
// Per-feature statistics (sum, sum of squares, max abs) in block memories,
// finalised to mean and std, and scaling of values by them.
// ----------------------------------------------------------------------------
// channel   signals                                   direction
// request   start, busy, req_type, feature_index, value   in (busy out)
// result    done, scaled_value, status                out
// config    cfg_we, cfg_index, cfg_data               in
//
// clear and error beats are answered from idle, zero std after the read.
// train: memory read, modify, write back. scale: two memory states then
// the shared one-bit-a-cycle divider (48 steps). finalize, per feature
// (all 16): read, load, multiply, subtract, divider (40 + 80 steps) with
// the mean between, square root (32 steps) and write back.
// reset clears all statistics at once through per-entry valid bits.
// results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module feature_standardize_maxabs_scaler
    import fsms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                req_type,
    input  logic [FeatIdxW-1:0]       feature_index,
    input  logic signed [DataW-1:0]   value,
    output logic                      done,
    output logic signed [31:0]        scaled_value,
    output logic [1:0]                status,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [FeatCntW-1:0]       cfg_data
);

    fsms_state_t state_reg, state_next;

    // configuration and control
    logic [FeatCntW-1:0]    feature_count_reg;
    logic                   scale_mode_reg;
    logic [CountW-1:0]      sample_count_reg, sample_count_next;
    logic [MaxFeatures-1:0] stat_vld_reg, stat_vld_next;
    logic [MaxFeatures-1:0] ms_vld_reg, ms_vld_next;
    logic                   done_reg, done_next;

    // captured request
    logic [1:0]               req_reg;
    logic [FeatIdxW-1:0]      idx_reg;
    logic signed [DataW-1:0]  x_reg;
    logic [FeatIdxW-1:0]      f_reg, f_next;

    // result
    logic [31:0] res_val_reg, res_val_next;
    logic [1:0]  res_st_reg, res_st_next;

    // memories
    logic [StatW-1:0] stat_mem [MaxFeatures];
    logic [MsW-1:0]   ms_mem [MaxFeatures];
    logic [StatW-1:0] stat_rd_reg;
    logic [MsW-1:0]   ms_rd_reg;
    logic [FeatIdxW-1:0] mem_addr;
    logic             stat_we, ms_we;
    logic [StatW-1:0] stat_wdata;
    logic [MsW-1:0]   ms_wdata;

    // finalize datapath
    logic [SumSqW-1:0]      s2_reg, s2_next;
    logic [39:0]            plo_reg, plo_next;
    logic [63:0]            a_reg, a_next;
    logic [63:0]            bsq_reg, bsq_next;
    logic [MeanW-1:0]       mean_reg, mean_next;
    logic                   neg_reg, neg_next;

    // shared divider
    logic [DvdW-1:0]    div_dvd_reg, div_dvd_next;
    logic [DvdW-1:0]    div_quo_reg, div_quo_next;
    logic [DenW-1:0]    div_rem_reg, div_rem_next;
    logic [DenW-1:0]    div_den_reg, div_den_next;
    logic [DivCntW-1:0] div_cnt_reg, div_cnt_next;

    // square root
    logic [63:0] sq_v_reg, sq_v_next;
    logic [63:0] sq_res_reg, sq_res_next;
    logic [63:0] sq_bit_reg, sq_bit_next;

    // combinational helpers
    logic [FeatCntW-1:0]     fc;
    logic                    accept;
    logic                    idx_bad;
    logic [SumW-1:0]         rd_sum;
    logic [SumSqW-1:0]       rd_sumsq;
    logic [MaxAbsW-1:0]      rd_max;
    logic [MeanW-1:0]        rd_mean;
    logic [StdW-1:0]         rd_std;
    logic [DataW:0]          ax;
    logic [DenW:0]           div_sh;
    logic                    div_ge;
    logic                    div_last;
    logic [63:0]             sq_try;
    logic [SumW-1:0]         abs_s1;
    logic [39:0]             mean_mag;
    logic [39:0]             phi;
    logic [39:0]             mq;
    logic [47:0]             sq48;
    logic signed [25:0]      dsc;
    logic [25:0]             dmag;

    assign fc = (feature_count_reg == '0) ? FeatCntW'(1) :
                (feature_count_reg > FeatCntW'(MaxFeatures)) ? FeatCntW'(MaxFeatures) :
                feature_count_reg;
    assign accept  = start && (state_reg == S_IDLE);
    assign idx_bad = {1'b0, feature_index} >= fc;

    // masked read data: an entry never written since clear reads as zero
    assign rd_sum   = stat_vld_reg[mem_addr] ? stat_rd_reg[StatW-1 -: SumW] : '0;
    assign rd_sumsq = stat_vld_reg[mem_addr] ? stat_rd_reg[MaxAbsW +: SumSqW] : '0;
    assign rd_max   = stat_vld_reg[mem_addr] ? stat_rd_reg[MaxAbsW-1:0] : '0;
    assign rd_mean  = ms_vld_reg[mem_addr] ? ms_rd_reg[MsW-1 -: MeanW] : '0;
    assign rd_std   = ms_vld_reg[mem_addr] ? ms_rd_reg[StdW-1:0] : '0;

    assign ax = x_reg[DataW-1] ? (DataW+1)'(-$signed({x_reg[DataW-1], x_reg}))
                               : (DataW+1)'({1'b0, x_reg});

    // one restoring divide step
    assign div_sh   = {div_rem_reg, div_dvd_reg[DvdW-1]};
    assign div_ge   = div_sh >= {1'b0, div_den_reg};
    assign div_last = div_cnt_reg == DivCntW'(1);

    assign sq_try = sq_res_reg + sq_bit_reg;

    assign abs_s1   = rd_sum[SumW-1] ? (~rd_sum + SumW'(1)) : rd_sum;
    assign mean_mag = {abs_s1, 8'h00} + 40'(sample_count_reg >> 1);
    assign phi      = 40'(sample_count_reg) * 40'(s2_reg[47:24]);
    assign mq       = div_quo_reg[39:0];
    assign sq48     = div_quo_reg[47:0];
    assign dsc      = 26'($signed({x_reg, 8'h00})) - 26'($signed(rd_mean));
    assign dmag     = dsc[25] ? 26'(-dsc) : 26'(dsc);

    assign mem_addr = (state_reg == S_FN_RD || state_reg == S_FN_LD || state_reg == S_FN_WB)
                      ? f_reg : idx_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[mem_addr] <= stat_wdata;
        end
        stat_rd_reg <= stat_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ms_we)
        begin
            ms_mem[mem_addr] <= ms_wdata;
        end
        ms_rd_reg <= ms_mem[mem_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_TRAIN:    state_next = (idx_bad || sample_count_reg >= SampleLimit)
                                                   ? S_IDLE : S_TR_RD;
                        REQ_FINALIZE: state_next = (sample_count_reg == '0) ? S_IDLE : S_FN_RD;
                        REQ_SCALE:    state_next = (idx_bad || sample_count_reg == '0)
                                                   ? S_IDLE : S_SC_RD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_TR_RD:   state_next = S_TR_WR;
            S_TR_WR:   state_next = S_IDLE;
            S_FN_RD:   state_next = S_FN_LD;
            S_FN_LD:   state_next = S_FN_MUL;
            S_FN_MUL:  state_next = S_FN_SUB;
            S_FN_SUB:  state_next = S_FN_MDIV;
            S_FN_MDIV: state_next = div_last ? S_FN_MEAN : S_FN_MDIV;
            S_FN_MEAN: state_next = S_FN_SDIV;
            S_FN_SDIV: state_next = div_last ? S_FN_SQLD : S_FN_SDIV;
            S_FN_SQLD: state_next = S_FN_SQRT;
            S_FN_SQRT: state_next = sq_bit_reg[0] ? S_FN_WB : S_FN_SQRT;
            S_FN_WB:   state_next = (f_reg == FeatIdxW'(MaxFeatures - 1)) ? S_IDLE : S_FN_RD;
            S_SC_RD:   state_next = S_SC_LD;
            S_SC_LD:   state_next = (scale_mode_reg == 1'b0 && rd_std == '0)
                                    ? S_IDLE : S_SC_DIV;
            S_SC_DIV:  state_next = div_last ? S_IDLE : S_SC_DIV;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sample_count_next = sample_count_reg;
        stat_vld_next     = stat_vld_reg;
        ms_vld_next       = ms_vld_reg;
        done_next         = 1'b0;
        res_val_next      = '0;
        res_st_next       = ST_OK;
        f_next            = f_reg;
        s2_next           = s2_reg;
        plo_next          = plo_reg;
        a_next            = a_reg;
        bsq_next          = bsq_reg;
        mean_next         = mean_reg;
        neg_next          = neg_reg;
        div_dvd_next      = div_dvd_reg;
        div_quo_next      = div_quo_reg;
        div_rem_next      = div_rem_reg;
        div_den_next      = div_den_reg;
        div_cnt_next      = div_cnt_reg;
        sq_v_next         = sq_v_reg;
        sq_res_next       = sq_res_reg;
        sq_bit_next       = sq_bit_reg;
        stat_we           = 1'b0;
        ms_we             = 1'b0;
        stat_wdata        = '0;
        ms_wdata          = '0;

        case (state_reg)
            S_IDLE:
            begin
                f_next = '0;
                if (accept)
                begin
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            stat_vld_next     = '0;
                            ms_vld_next       = '0;
                            sample_count_next = '0;
                            done_next         = 1'b1;
                        end
                        REQ_TRAIN:
                        begin
                            if (idx_bad)
                            begin
                                res_st_next = ST_BAD_IDX;
                                done_next   = 1'b1;
                            end
                            else if (sample_count_reg >= SampleLimit)
                            begin
                                done_next = 1'b1;
                            end
                        end
                        REQ_FINALIZE:
                        begin
                            if (sample_count_reg == '0)
                            begin
                                res_st_next = ST_NO_SAMP;
                                done_next   = 1'b1;
                            end
                        end
                        REQ_SCALE:
                        begin
                            if (idx_bad)
                            begin
                                res_st_next = ST_BAD_IDX;
                                done_next   = 1'b1;
                            end
                            else if (sample_count_reg == '0)
                            begin
                                res_st_next = ST_NO_SAMP;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_TR_WR:
            begin
                stat_we    = 1'b1;
                stat_wdata = {rd_sum + SumW'($signed(x_reg)),
                              rd_sumsq + SumSqW'(ax * ax),
                              ({1'b0, rd_max} < ax) ? ax[MaxAbsW-1:0] : rd_max};
                stat_vld_next[mem_addr] = 1'b1;
                if ({1'b0, idx_reg} == fc - FeatCntW'(1))
                begin
                    sample_count_next = sample_count_reg + CountW'(1);
                end
                done_next = 1'b1;
            end
            S_FN_LD:
            begin
                s2_next  = rd_sumsq;
                plo_next = 40'(sample_count_reg) * 40'(rd_sumsq[23:0]);
                bsq_next = 64'(abs_s1) * 64'(abs_s1);
                neg_next = rd_sum[SumW-1];
                // rounded mean: (|sum|*256 + n/2) / n
                div_dvd_next = {mean_mag, 40'h0};
                div_den_next = DenW'(sample_count_reg);
            end
            S_FN_MUL:
            begin
                a_next = 64'(plo_reg) + {phi, 24'h0};
            end
            S_FN_SUB:
            begin
                a_next       = (a_reg > bsq_reg) ? a_reg - bsq_reg : '0;
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DivCntW'(40);
            end
            S_FN_MEAN:
            begin
                if (neg_reg)
                begin
                    mean_next = (mq > 40'h800000) ? 24'h800000 : 24'(-mq);
                end
                else
                begin
                    mean_next = (mq > 40'h7FFFFF) ? 24'h7FFFFF : mq[MeanW-1:0];
                end
                // std: (n*sumsq - sum^2) * 2^16 / n^2
                div_dvd_next = {a_reg, 16'h0};
                div_den_next = 32'(sample_count_reg) * 32'(sample_count_reg);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DivCntW'(DvdW);
            end
            S_FN_SQLD:
            begin
                // integer part clamps to 46 bits, fraction bits kept
                if (div_quo_reg[DvdW-1:62] != '0)
                begin
                    sq_v_next = {2'b00, 46'h3FFF_FFFF_FFFF, div_quo_reg[15:0]};
                end
                else
                begin
                    sq_v_next = div_quo_reg[63:0];
                end
                sq_res_next = '0;
                sq_bit_next = 64'h4000_0000_0000_0000;
            end
            S_FN_SQRT:
            begin
                if (sq_v_reg >= sq_try)
                begin
                    sq_v_next   = sq_v_reg - sq_try;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            S_FN_WB:
            begin
                ms_we    = 1'b1;
                ms_wdata = {mean_reg,
                            (sq_res_reg > 64'hFF_FFFF) ? 24'hFF_FFFF : sq_res_reg[StdW-1:0]};
                ms_vld_next[mem_addr] = 1'b1;
                f_next = f_reg + FeatIdxW'(1);
                if (f_reg == FeatIdxW'(MaxFeatures - 1))
                begin
                    done_next = 1'b1;
                end
            end
            S_SC_LD:
            begin
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = DivCntW'(48);
                if (scale_mode_reg == 1'b0)
                begin
                    neg_next     = dsc[25];
                    div_dvd_next = {48'({dmag, 16'h0}), 32'h0};
                    div_den_next = DenW'(rd_std);
                    if (rd_std == '0)
                    begin
                        res_st_next = ST_ZERO_STD;
                        done_next   = 1'b1;
                    end
                end
                else
                begin
                    neg_next     = x_reg[DataW-1];
                    div_dvd_next = {48'({ax, 16'h0}), 32'h0};
                    div_den_next = (rd_max == '0) ? DenW'(256) : DenW'(rd_max);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        if (state_reg == S_FN_MDIV || state_reg == S_FN_SDIV || state_reg == S_SC_DIV)
        begin
            div_rem_next = div_ge ? DenW'(div_sh - {1'b0, div_den_reg}) : div_sh[DenW-1:0];
            div_quo_next = {div_quo_reg[DvdW-2:0], div_ge};
            div_dvd_next = {div_dvd_reg[DvdW-2:0], 1'b0};
            div_cnt_next = div_cnt_reg - DivCntW'(1);
        end

        // the scale quotient saturates at the last step, which also raises done
        if (state_reg == S_SC_DIV && div_last)
        begin
            done_next = 1'b1;
        end
    end

    // saturation of the finished scale quotient, taken from the last step
    logic [47:0] sc_q;
    assign sc_q = {sq48[46:0], div_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            feature_count_reg <= FeatCntW'(MaxFeatures);
            scale_mode_reg    <= 1'b0;
            sample_count_reg  <= '0;
            stat_vld_reg      <= '0;
            ms_vld_reg        <= '0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_count_reg <= sample_count_next;
            stat_vld_reg     <= stat_vld_next;
            ms_vld_reg       <= ms_vld_next;
            done_reg         <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FEATURE_COUNT: feature_count_reg <= cfg_data;
                    REG_SCALE_MODE:    scale_mode_reg    <= cfg_data[0];
                    default:           scale_mode_reg    <= scale_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            idx_reg <= feature_index;
            x_reg   <= value;
        end
        f_reg       <= f_next;
        s2_reg      <= s2_next;
        plo_reg     <= plo_next;
        a_reg       <= a_next;
        bsq_reg     <= bsq_next;
        mean_reg    <= mean_next;
        neg_reg     <= neg_next;
        div_dvd_reg <= div_dvd_next;
        div_quo_reg <= div_quo_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        sq_v_reg    <= sq_v_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        res_st_reg  <= res_st_next;
        if (state_reg == S_SC_DIV && div_last && req_reg == REQ_SCALE)
        begin
            if (neg_reg)
            begin
                res_val_reg <= (sc_q >= 48'h8000_0000) ? 32'h8000_0000 : 32'(-sc_q);
            end
            else
            begin
                res_val_reg <= (sc_q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : sc_q[31:0];
            end
        end
        else
        begin
            res_val_reg <= res_val_next;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign scaled_value = res_val_reg;
    assign status       = res_st_reg;

    // a result beat always lands back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither started work nor answered");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (scaled_value == '0))
        else $error("error result carries a nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stat_we || ms_we) |-> busy)
        else $error("memory written while idle");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feature standardiser / max-abs scaler. A driver
// sends requests in random bursts and a monitor checks every result beat
// against a predictor of the per-feature statistics, mean, std and scaling.
// ----------------------------------------------------------------------------
module tb_top;
    import fsms_pkg::*;

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t              kind;
        logic [1:0]              req;
        logic [FeatIdxW-1:0]     idx;
        logic signed [DataW-1:0] val;
        logic                    reg_idx;
        logic [FeatCntW-1:0]     reg_data;
    } stim_t;

    typedef struct {
        logic [31:0] scaled;
        logic [1:0]  stat;
    } answer_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              req_type = REQ_CLEAR;
    logic [FeatIdxW-1:0]     feature_index = '0;
    logic signed [DataW-1:0] value = '0;
    logic                    done;
    logic signed [31:0]      scaled_value;
    logic [1:0]              status;
    logic                    cfg_we = 1'b0;
    logic                    cfg_index = 1'b0;
    logic [FeatCntW-1:0]     cfg_data = '0;

    stim_t   pending_q[$];
    answer_t answer_q[$];
    int      fail_cnt = 0;
    logic    taken = 1'b0;
    int      gap_left = 0;
    int      burst_left = 1;
    int      quiet_cycles = 0;

    // predictor state
    bit [SumW-1:0]    acc_sum[MaxFeatures];
    bit [SumSqW-1:0]  acc_sq[MaxFeatures];
    bit [MaxAbsW-1:0] acc_max[MaxFeatures];
    bit [MeanW-1:0]   stat_mean[MaxFeatures];
    bit [StdW-1:0]    stat_std[MaxFeatures];
    bit [CountW-1:0]  rows_done = '0;
    bit [FeatCntW-1:0] feat_cnt_reg = 5'd16;
    bit               mode_reg = 1'b0;

    feature_standardize_maxabs_scaler dut (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // truncate toward zero, saturate to 32 bits
    function automatic logic [31:0] div_sat(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(0) - num : num;
        q = mag / den;
        if (num < 0) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
    endfunction

    function automatic int unsigned feats_in_use();
        if (feat_cnt_reg < 1) return 1;
        if (feat_cnt_reg > MaxFeatures) return MaxFeatures;
        return feat_cnt_reg;
    endfunction

    function automatic void wipe_stats();
        for (int f = 0; f < MaxFeatures; f++) begin
            acc_sum[f] = '0; acc_sq[f] = '0; acc_max[f] = '0;
            stat_mean[f] = '0; stat_std[f] = '0;
        end
        rows_done = '0;
    endfunction

    function automatic void finalise_feature(int f, longint unsigned n);
        longint s1, sc, mn;
        longint unsigned s2, mag, q, a, b, num, nn, v, sd;
        s1 = longint'($signed(acc_sum[f]));
        s2 = acc_sq[f];
        sc = s1 * 256;
        mag = (sc < 0) ? longint'(0) - sc : sc;
        q = (mag + n / 2) / n;
        if (sc < 0) mn = (q > 64'h80_0000) ? -64'sh80_0000 : -longint'(q);
        else mn = (q > 64'h7F_FFFF) ? 64'sh7F_FFFF : longint'(q);
        stat_mean[f] = mn[MeanW-1:0];
        a = n * s2;
        b = (s1 < 0) ? -s1 : s1;
        b = b * b;
        num = (a > b) ? a - b : 0;
        nn = n * n;
        q = num / nn;
        if (q > 64'h3FFF_FFFF_FFFF) q = 64'h3FFF_FFFF_FFFF;
        v = (q << 16) + ((num % nn) << 16) / nn;
        sd = root64(v);
        stat_std[f] = (sd > 64'hFF_FFFF) ? 24'hFF_FFFF : sd[StdW-1:0];
    endfunction

    function automatic answer_t predict_answer(logic [1:0] rq, logic [FeatIdxW-1:0] ix,
                                               logic signed [DataW-1:0] x);
        answer_t ans;
        int unsigned fc;
        longint xv, d;
        longint unsigned ax, m;
        ans.scaled = '0;
        ans.stat = ST_OK;
        fc = feats_in_use();
        xv = x;
        case (rq)
            REQ_CLEAR: wipe_stats();
            REQ_TRAIN: begin
                if (ix >= fc) ans.stat = ST_BAD_IDX;
                else if (rows_done < SampleLimit) begin
                    ax = (xv < 0) ? -xv : xv;
                    acc_sum[ix] = acc_sum[ix] + 32'(xv);
                    acc_sq[ix] = acc_sq[ix] + 48'(ax * ax);
                    if (ax > acc_max[ix]) acc_max[ix] = ax[MaxAbsW-1:0];
                    if (ix == fc - 1) rows_done = rows_done + 1'b1;
                end
            end
            REQ_FINALIZE: begin
                if (rows_done == 0) ans.stat = ST_NO_SAMP;
                else for (int f = 0; f < MaxFeatures; f++) finalise_feature(f, rows_done);
            end
            default: begin
                if (ix >= fc) ans.stat = ST_BAD_IDX;
                else if (rows_done == 0) ans.stat = ST_NO_SAMP;
                else if (!mode_reg) begin
                    if (stat_std[ix] == 0) ans.stat = ST_ZERO_STD;
                    else begin
                        d = xv * 256 - longint'($signed(stat_mean[ix]));
                        ans.scaled = div_sat(d * 65536, stat_std[ix]);
                    end
                end else begin
                    m = (acc_max[ix] == 0) ? 256 : acc_max[ix];
                    ans.scaled = div_sat(xv * 65536, m);
                end
            end
        endcase
        return ans;
    endfunction

    // monitor: checks result beats, then predicts newly accepted beats
    always @(posedge clk) begin
        answer_t want;
        if (rst_n) begin
            taken <= start && !busy;
            if (done) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result beat: scaled_value %0d status %0d",
                           scaled_value, status);
                    fail_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    if (scaled_value !== want.scaled) begin
                        $error("scaled_value: expected %0d, actual %0d",
                               $signed(want.scaled), scaled_value);
                        fail_cnt++;
                    end
                    if (status !== want.stat) begin
                        $error("status: expected %0d, actual %0d", want.stat, status);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_we) begin
                if (cfg_index == REG_FEATURE_COUNT) feat_cnt_reg = cfg_data;
                else mode_reg = cfg_data[0];
            end
            if (start && !busy)
                answer_q.push_back(predict_answer(req_type, feature_index, value));
            quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
        end
    end

    always @(posedge clk) begin
        if (quiet_cycles > 20000) begin
            $display("[feature_standardize_maxabs_scaler] ERROR");
            $finish;
        end
    end

    // driver
    always @(negedge clk) begin
        logic    nx_start, nx_we;
        stim_t   head;
        nx_start = start;
        nx_we = 1'b0;
        if (rst_n && !(start && !taken)) begin
            nx_start = 1'b0;
            if (gap_left > 0) gap_left--;
            else if (pending_q.size() > 0) begin
                head = pending_q[0];
                case (head.kind)
                    K_ITEM: begin
                        void'(pending_q.pop_front());
                        nx_start = 1'b1;
                        req_type <= head.req;
                        feature_index <= head.idx;
                        value <= head.val;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        end
                    end
                    K_CFG: if (answer_q.size() == 0 && !busy && !taken) begin
                        void'(pending_q.pop_front());
                        nx_we = 1'b1;
                        cfg_index <= head.reg_idx;
                        cfg_data <= head.reg_data;
                    end
                    default: if (answer_q.size() == 0 && !busy && !taken)
                        void'(pending_q.pop_front());
                endcase
            end
        end
        start <= nx_start;
        cfg_we <= nx_we;
    end

    task automatic add_req(logic [1:0] rq, int ix, logic signed [DataW-1:0] x);
        stim_t s;
        s.kind = K_ITEM; s.req = rq; s.idx = ix[FeatIdxW-1:0]; s.val = x;
        s.reg_idx = 1'b0; s.reg_data = '0;
        pending_q.push_back(s);
    endtask

    task automatic add_write(logic ri, int d);
        stim_t s;
        s.kind = K_DRAIN;
        pending_q.push_back(s);
        s.kind = K_CFG; s.req = REQ_CLEAR; s.idx = '0; s.val = '0;
        s.reg_idx = ri; s.reg_data = d[FeatCntW-1:0];
        pending_q.push_back(s);
    endtask

    task automatic add_pause();
        stim_t s;
        s.kind = K_DRAIN;
        pending_q.push_back(s);
    endtask

    function automatic logic signed [DataW-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'($urandom_range(0, 16)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int fc, rows, eff;
        int cnt_opts[5] = '{0, 1, 5, 16, 31};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no samples, bad index, extremes, zero std, zero max
        add_write(REG_FEATURE_COUNT, 4);
        add_write(REG_SCALE_MODE, 0);
        add_req(REQ_SCALE, 0, 16'sd100);
        add_req(REQ_FINALIZE, 0, 0);
        add_req(REQ_TRAIN, 5, 16'sd7);
        add_req(REQ_SCALE, 15, 16'sd7);
        for (int r = 0; r < 2; r++) begin
            add_req(REQ_TRAIN, 0, -16'sd32768);
            add_req(REQ_TRAIN, 1, 16'sd32767);
            add_req(REQ_TRAIN, 2, 16'sd0);
            add_req(REQ_TRAIN, 3, r ? 16'sd1 : -16'sd1);
        end
        add_req(REQ_FINALIZE, 0, 0);
        add_req(REQ_SCALE, 2, 16'sd3);
        add_req(REQ_SCALE, 0, 16'sd32767);
        add_req(REQ_SCALE, 1, -16'sd32768);
        add_req(REQ_SCALE, 3, 16'sd1);
        add_write(REG_SCALE_MODE, 1);
        add_req(REQ_SCALE, 2, 16'sd5);
        add_req(REQ_SCALE, 0, -16'sd32768);
        add_req(REQ_SCALE, 3, 16'sd32767);
        add_req(REQ_CLEAR, 0, 0);
        add_req(REQ_SCALE, 0, 16'sd1);

        // random phases through several register settings
        for (int ph = 0; ph < 14; ph++) begin
            fc = (ph < 5) ? cnt_opts[ph] : $urandom_range(0, 31);
            eff = (fc < 1) ? 1 : (fc > 16 ? 16 : fc);
            add_write(REG_FEATURE_COUNT, fc);
            add_write(REG_SCALE_MODE, $urandom_range(0, 1));
            add_req(REQ_CLEAR, 0, 0);
            rows = $urandom_range(1, 40 / eff + 1);
            for (int r = 0; r < rows; r++) begin
                for (int i = 0; i < eff; i++) add_req(REQ_TRAIN, i, pick_value());
                if ($urandom_range(0, 4) == 0)
                    add_req(2'($urandom_range(0, 3)), $urandom_range(0, 15), pick_value());
            end
            add_req(REQ_FINALIZE, 0, 0);
            if (ph == 3) add_pause();
            for (int k = 0; k < 14; k++) add_req(REQ_SCALE, $urandom_range(0, 15), pick_value());
            add_write(REG_SCALE_MODE, ph % 2);
            for (int k = 0; k < 10; k++) add_req(REQ_SCALE, $urandom_range(0, eff - 1),
                                                pick_value());
        end

        while (pending_q.size() != 0 || answer_q.size() != 0 || start)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_cnt == 0 && answer_q.size() == 0)
            $display("[feature_standardize_maxabs_scaler] OK");
        else
            $display("[feature_standardize_maxabs_scaler] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/fsms_pkg.sv
rtl/feature_standardize_maxabs_scaler.sv
verif/tb_top.sv
